[design/stcb_pkg.sv]
// Shared types and constants for the serial tone command beeper.
package stcb_pkg;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int NUM_W      = 16;
    localparam int PITCH_W    = 11;
    localparam int CMP_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int DIV_CNT_W  = 4;

    // Item kinds
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PITCH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PITCH = 1'd1;

    // Configuration reset values
    localparam logic [PITCH_W-1:0] MIN_PITCH_RST = 11'd262;
    localparam logic [PITCH_W-1:0] MAX_PITCH_RST = 11'd2000;

    // Character codes
    localparam logic [BYTE_W-1:0] CR_CODE    = 8'h0D;
    localparam logic [BYTE_W-1:0] COMMA_CODE = 8'h2C;
    localparam logic [BYTE_W-1:0] DIGIT_0    = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_9    = 8'h39;

    // Tone timer numerator and limits
    localparam logic [NUM_W-1:0] TONE_NUMERATOR = 16'd62500;
    localparam logic [NUM_W-1:0] ACC_MAX        = 16'hFFFF;
    localparam logic [NUM_W-1:0] QUO_SAT_LIMIT  = 16'd256;
    localparam logic [CMP_W-1:0] CMP_MAX        = 8'hFF;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST   = 4'd15;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH
    } t_state;

    // Line parser view handed to the command logic on each byte beat
    typedef struct packed {
        logic             load;
        logic             pitch_seen;
        logic             dur_seen;
        logic [NUM_W-1:0] pitch_acc;
        logic [NUM_W-1:0] dur_acc;
    } t_line_evt;

endpackage

[design/stcb_in_if.sv]
// Input channel: item kind and received byte with valid/ready.
interface stcb_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

[design/stcb_out_if.sv]
// Output channel: tone compare value and status flags with valid/ready.
interface stcb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tone_compare;
    logic       beeping;
    logic       command_loaded;

    modport source (output valid, output tone_compare, output beeping,
                    output command_loaded, input ready);
    modport sink   (input valid, input tone_compare, input beeping,
                    input command_loaded, output ready);
endinterface

[design/stcb_line_parser.sv]
// Command line parser: line length, field select and decimal accumulators.
module stcb_line_parser #(
    parameter int LINE_LIMIT = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_byte_en,
    input  logic [stcb_pkg::BYTE_W-1:0]   i_byte,
    output stcb_pkg::t_line_evt           o_evt
);
    import stcb_pkg::*;

    localparam int LEN_W = $clog2(LINE_LIMIT);

    logic [LEN_W-1:0] r_len;
    logic             r_second;
    logic [NUM_W-1:0] r_pitch_acc;
    logic [NUM_W-1:0] r_dur_acc;
    logic             r_pitch_seen;
    logic             r_dur_seen;

    logic [LEN_W:0]   w_len_inc;
    logic             w_overlong;
    logic             w_is_cr;
    logic             w_is_digit;
    logic             w_is_comma;
    logic [NUM_W-1:0] w_acc_sel;
    logic [NUM_W+3:0] w_acc_x10;
    logic [NUM_W-1:0] n_acc;

    // Byte classification
    assign w_len_inc  = {1'b0, r_len} + {{LEN_W{1'b0}}, 1'b1};
    assign w_overlong = w_len_inc >= (LEN_W+1)'(LINE_LIMIT);
    assign w_is_cr    = i_byte == CR_CODE;
    assign w_is_digit = (i_byte >= DIGIT_0) && (i_byte <= DIGIT_9);
    assign w_is_comma = i_byte == COMMA_CODE;

    // acc*10 + digit as two shifted adds, saturating at 16 bits
    assign w_acc_sel = r_second ? r_dur_acc : r_pitch_acc;
    assign w_acc_x10 = {1'b0, w_acc_sel, 3'b000} + {3'b000, w_acc_sel, 1'b0}
                     + {16'd0, i_byte[3:0]};
    assign n_acc     = (w_acc_x10 > {4'd0, ACC_MAX}) ? ACC_MAX : w_acc_x10[NUM_W-1:0];

    // Event view of the line held before this byte
    assign o_evt.load       = i_byte_en && !w_overlong && w_is_cr;
    assign o_evt.pitch_seen = r_pitch_seen;
    assign o_evt.dur_seen   = r_dur_seen;
    assign o_evt.pitch_acc  = r_pitch_acc;
    assign o_evt.dur_acc    = r_dur_acc;

    // Line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= '0;
            r_second     <= 1'b0;
            r_pitch_acc  <= '0;
            r_dur_acc    <= '0;
            r_pitch_seen <= 1'b0;
            r_dur_seen   <= 1'b0;
        end else if (i_byte_en) begin
            if (w_overlong || w_is_cr) begin
                r_len        <= '0;
                r_second     <= 1'b0;
                r_pitch_acc  <= '0;
                r_dur_acc    <= '0;
                r_pitch_seen <= 1'b0;
                r_dur_seen   <= 1'b0;
            end else begin
                r_len <= w_len_inc[LEN_W-1:0];
                if (w_is_digit) begin
                    if (r_second) begin
                        r_dur_acc  <= n_acc;
                        r_dur_seen <= 1'b1;
                    end else begin
                        r_pitch_acc  <= n_acc;
                        r_pitch_seen <= 1'b1;
                    end
                end else if (w_is_comma) begin
                    r_second <= 1'b1;
                end
            end
        end
    end

endmodule

[design/stcb_tone_div.sv]
// Bit-serial restoring divider: 62500 / pitch - 1, saturated to 8 bits.
module stcb_tone_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [stcb_pkg::PITCH_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [stcb_pkg::CMP_W-1:0]    o_compare
);
    import stcb_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PITCH_W-1:0]   r_div;
    logic [PITCH_W-1:0]   r_rem;
    logic [NUM_W-1:0]     r_quo;

    logic [PITCH_W:0]     w_trial;
    logic [PITCH_W+1:0]   w_diff;
    logic                 w_borrow;

    // One quotient bit per cycle, dividend shifts out as quotient shifts in
    assign w_trial  = {r_rem, r_quo[NUM_W-1]};
    assign w_diff   = {1'b0, w_trial} - {2'b00, r_div};
    assign w_borrow = w_diff[PITCH_W+1];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= TONE_NUMERATOR;
        end else if (r_busy) begin
            r_rem <= w_borrow ? w_trial[PITCH_W-1:0] : w_diff[PITCH_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ~w_borrow};
        end
    end

    // Quotient minus one, saturated
    assign o_done    = r_done;
    assign o_compare = (r_quo > QUO_SAT_LIMIT) ? CMP_MAX
                                               : CMP_W'(r_quo - 16'd1);

endmodule

[design/serial_tone_command_beeper.sv]
// Top level: serial tone command beeper with sequencer, tick counter and output register.
//
//  Channel  Dir  Beat contents                         Handshake
//  i_in     in   func, rx_byte                         valid/ready
//  o_out    out  tone_compare, beeping, command_loaded valid/ready
//  i_cfg    in   i_cfg_idx, i_cfg_data                 i_cfg_we, no wait
//
// A tick or a plain byte is accepted in ST_IDLE, then handed to the output register
// in ST_PUSH. A carriage return that completes a command passes through ST_DIV between
// the two, while the 16-step bit-serial divider forms the tone compare value.
// Synchronous active-low reset clears control and command state, restores pitch limits.
// A new input beat is taken while an earlier result waits in the output register;
// a second result is held until the output register frees.
module serial_tone_command_beeper #(
    parameter int LINE_LIMIT = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    stcb_in_if.sink                           i_in,
    stcb_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [stcb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [stcb_pkg::PITCH_W-1:0]      i_cfg_data
);
    import stcb_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [PITCH_W-1:0] r_min_pitch;
    logic [PITCH_W-1:0] r_max_pitch;
    logic [NUM_W-1:0]   r_pitch_value;
    logic [NUM_W-1:0]   r_dur_value;
    logic [NUM_W-1:0]   r_tick_count;
    logic               r_beep;
    logic [CMP_W-1:0]   r_compare;
    logic               r_loaded;

    logic               r_out_valid;
    logic [CMP_W-1:0]   r_out_cmp;
    logic               r_out_beep;
    logic               r_out_loaded;

    logic               w_accept;
    logic               w_byte_en;
    logic               w_push;
    logic               w_out_free;
    logic [NUM_W-1:0]   w_pv;
    logic [PITCH_W-1:0] w_hz;
    logic               w_div_done;
    logic [CMP_W-1:0]   w_div_cmp;
    t_line_evt          w_evt;

    // Handshake
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_byte_en  = w_accept && (i_in.func == FUNC_BYTE);
    assign w_out_free = !r_out_valid || o_out.ready;

    // Line parser
    stcb_line_parser #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (w_byte_en),
        .i_byte    (i_in.rx_byte),
        .o_evt     (w_evt)
    );

    // Pitch select and clamp, upper bound first
    assign w_pv = w_evt.pitch_seen ? w_evt.pitch_acc : r_pitch_value;
    always_comb begin
        priority if (w_pv > {5'd0, r_max_pitch}) begin
            w_hz = r_max_pitch;
        end else if (w_pv < {5'd0, r_min_pitch}) begin
            w_hz = r_min_pitch;
        end else begin
            w_hz = w_pv[PITCH_W-1:0];
        end
    end

    // Tone divider
    stcb_tone_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_evt.load),
        .i_divisor (w_hz),
        .o_done    (w_div_done),
        .o_compare (w_div_cmp)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state and controls
    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        w_push     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (w_accept) begin
                    n_state = w_evt.load ? ST_DIV : ST_PUSH;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (w_out_free) begin
                    w_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration, command and tick state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pitch   <= MIN_PITCH_RST;
            r_max_pitch   <= MAX_PITCH_RST;
            r_pitch_value <= '0;
            r_dur_value   <= '0;
            r_tick_count  <= '0;
            r_beep        <= 1'b0;
            r_compare     <= '0;
            r_loaded      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MIN_PITCH) begin
                    r_min_pitch <= i_cfg_data;
                end
                if (i_cfg_idx == CFG_MAX_PITCH) begin
                    r_max_pitch <= i_cfg_data;
                end
            end
            if (w_accept) begin
                r_loaded <= w_evt.load;
                if (i_in.func == FUNC_TICK) begin
                    if (r_beep && (r_tick_count < r_dur_value)) begin
                        r_tick_count <= r_tick_count + 16'd1;
                    end else begin
                        r_compare    <= '0;
                        r_tick_count <= '0;
                        r_beep       <= 1'b0;
                    end
                end else if (w_evt.load) begin
                    r_pitch_value <= {5'd0, w_hz};
                    if (w_evt.pitch_seen && w_evt.dur_seen) begin
                        r_dur_value <= w_evt.dur_acc;
                    end
                    r_beep <= 1'b1;
                end
            end
            if (w_div_done) begin
                r_compare <= w_div_cmp;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_cmp    <= r_compare;
            r_out_beep   <= r_beep;
            r_out_loaded <= r_loaded;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.tone_compare   = r_out_cmp;
    assign o_out.beeping        = r_out_beep;
    assign o_out.command_loaded = r_out_loaded;

`ifndef SYNTHESIS
    // Silence always carries a zero compare value
    a_silent_zero: assert property (@(posedge i_clk)
        (i_rst_n && !r_beep) |-> (r_compare == '0))
        else $error("compare value nonzero while not beeping");

    // A completed command always goes through the divider
    a_load_div: assert property (@(posedge i_clk)
        (i_rst_n && w_accept && w_evt.load) |=> (r_state == ST_DIV))
        else $error("command load did not start the divide");

    // Divider finishes only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk)
        (i_rst_n && w_div_done) |-> (r_state == ST_DIV))
        else $error("divider done outside divide state");
`endif

endmodule

[verif/serial_tone_command_beeper_tb.sv]
// Self-checking testbench for the serial tone command beeper: directed and random traffic.
`timescale 1ns / 100ps

module serial_tone_command_beeper_tb;
    import stcb_pkg::*;

    localparam int LINE_LIMIT     = 16;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int RANDOM_PHASES  = 7;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SHOW_LIMIT     = 10;

    // One status beat as it leaves the block
    typedef struct packed {
        logic [CMP_W-1:0] tone;
        logic             beep;
        logic             loaded;
    } t_tone_status;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [PITCH_W-1:0]   i_cfg_data;

    stcb_in_if  in_ch ();
    stcb_out_if out_ch ();

    serial_tone_command_beeper #(
        .LINE_LIMIT (LINE_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Beeper shadow state
    logic [PITCH_W-1:0] lim_lo;
    logic [PITCH_W-1:0] lim_hi;
    int unsigned        line_len;
    logic               second_fld;
    logic [NUM_W-1:0]   pitch_acc;
    logic               pitch_seen;
    logic [NUM_W-1:0]   dur_acc;
    logic               dur_seen;
    logic [NUM_W-1:0]   pitch_hz;
    logic [NUM_W-1:0]   dur_ms;
    logic [NUM_W-1:0]   tick_cnt;
    logic               tone_on;
    logic [CMP_W-1:0]   cmp_val;

    t_tone_status expected_status[$];
    logic [BYTE_W-1:0] line_buf[$];

    // Run bookkeeping
    int  items_sent;
    int  ticks_sent;
    int  results_seen;
    int  loads_predicted;
    int  lines_dropped;
    int  settings_applied;
    int  errors;
    int  shown;
    int  quiet_cycles;
    int  stall_left;
    bit  calm;

    t_tone_status got_st;
    t_tone_status want_st;

    function automatic void clear_line();
        line_len   = 0;
        second_fld = 1'b0;
        pitch_acc  = '0;
        pitch_seen = 1'b0;
        dur_acc    = '0;
        dur_seen   = 1'b0;
    endfunction

    function automatic void reset_beeper();
        lim_lo   = MIN_PITCH_RST;
        lim_hi   = MAX_PITCH_RST;
        clear_line();
        pitch_hz = '0;
        dur_ms   = '0;
        tick_cnt = '0;
        tone_on  = 1'b0;
        cmp_val  = '0;
    endfunction

    // Decimal digit into a 16-bit accumulator that sticks at all ones
    function automatic logic [NUM_W-1:0] add_digit(logic [NUM_W-1:0] acc,
                                                   logic [BYTE_W-1:0] ch);
        int unsigned v;
        v = 32'(acc);
        v = v * 10 + 32'(ch - DIGIT_0);
        return (v > ACC_MAX) ? ACC_MAX : v[NUM_W-1:0];
    endfunction

    // Timer compare for a pitch; zero pitch and low pitches pin at full scale
    function automatic logic [CMP_W-1:0] tone_cmp(int unsigned hz);
        int unsigned q;
        if (hz == 0)
            return CMP_MAX;
        q = 62500 / hz - 1;
        return (q > 255) ? CMP_MAX : q[CMP_W-1:0];
    endfunction

    function automatic void load_command();
        int unsigned hz;
        if (pitch_seen) begin
            pitch_hz = pitch_acc;
            if (dur_seen)
                dur_ms = dur_acc;
        end
        hz = 32'(pitch_hz);
        // upper bound wins when the limits cross
        if (hz > lim_hi)
            hz = 32'(lim_hi);
        else if (hz < lim_lo)
            hz = 32'(lim_lo);
        pitch_hz = hz[NUM_W-1:0];
        cmp_val  = tone_cmp(hz);
        tone_on  = 1'b1;
        loads_predicted++;
    endfunction

    // Advance the shadow beeper by one accepted beat and queue its status
    function automatic void predict_beat(logic kind, logic [BYTE_W-1:0] ch);
        t_tone_status st;
        st.loaded = 1'b0;
        if (kind == FUNC_BYTE) begin
            line_len++;
            if (line_len >= LINE_LIMIT) begin
                clear_line();
                lines_dropped++;
            end else if (ch == CR_CODE) begin
                load_command();
                st.loaded = 1'b1;
                clear_line();
            end else if (ch >= DIGIT_0 && ch <= DIGIT_9) begin
                if (second_fld) begin
                    dur_acc  = add_digit(dur_acc, ch);
                    dur_seen = 1'b1;
                end else begin
                    pitch_acc  = add_digit(pitch_acc, ch);
                    pitch_seen = 1'b1;
                end
            end else if (ch == COMMA_CODE) begin
                second_fld = 1'b1;
            end
        end else begin
            if (tone_on && tick_cnt < dur_ms) begin
                tick_cnt = tick_cnt + 1'b1;
            end else begin
                cmp_val  = '0;
                tick_cnt = '0;
                tone_on  = 1'b0;
            end
        end
        st.tone = cmp_val;
        st.beep = tone_on;
        expected_status.push_back(st);
    endfunction

    // Mostly no gap, sometimes a few cycles, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] junk_byte();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(0, 255));
        while (b == CR_CODE);
        return b;
    endfunction

    // Send one beat; called and returns at a falling edge
    task automatic send_beat(input logic kind, input logic [BYTE_W-1:0] data);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.func    <= kind;
        in_ch.rx_byte <= data;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        predict_beat(kind, data);
        items_sent++;
        if (kind == FUNC_TICK)
            ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_beat(FUNC_TICK, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic send_line_buf();
        foreach (line_buf[i])
            send_beat(FUNC_BYTE, line_buf[i]);
        line_buf.delete();
    endtask

    // Text of a command line followed by the carriage return
    task automatic send_command(input string s);
        put_text(s);
        send_line_buf();
        send_beat(FUNC_BYTE, CR_CODE);
    endtask

    // Hold the sender until every queued status beat has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_status.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Both limits are written back to back while the block is idle
    task automatic set_limits(input logic [PITCH_W-1:0] lo, input logic [PITCH_W-1:0] hi);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MIN_PITCH;
        i_cfg_data <= lo;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_MAX_PITCH;
        i_cfg_data <= hi;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        lim_lo = lo;
        lim_hi = hi;
        settings_applied++;
    endtask

    // Ticks straight out of reset stay silent
    task automatic test_idle_ticks();
        send_beat(FUNC_TICK, 8'h00);
        send_beat(FUNC_TICK, 8'hFF);
    endtask

    // Basic lines, duration count, missing fields, extra commas and junk
    task automatic test_command_lines();
        send_command("0");
        send_command("500,2");
        send_ticks(4);
        send_command(",7");
        send_command("300");
        send_command("1,2,3 +a-");
        send_ticks(3);
    endtask

    // Saturating numbers right under the line limit, then a line that hits it
    task automatic test_line_limit();
        send_command("9999999,999999");
        send_command("99999999,999999");
        send_command("700,1");
        send_ticks(2);
    endtask

    // Zero pitch, compare saturation edges, crossed limits
    task automatic test_pitch_limits();
        set_limits(11'd0, 11'd2000);
        send_command("0,1");
        send_command("244");
        send_command("246");
        send_command("2047");
        set_limits(11'd2000, 11'd246);
        send_command("1000");
        send_command("100");
        set_limits(MIN_PITCH_RST, MAX_PITCH_RST);
    endtask

    // Random well-formed line with the odd junk byte or overlong tail
    task automatic send_random_line();
        int unsigned pitch_num;
        int unsigned dur_num;
        int          pick;
        int          slot;
        int          pad_to;
        line_buf.delete();
        if ($urandom_range(0, 99) >= 8) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                pitch_num = $urandom_range(200, 2100);
            else if (pick < 90)
                pitch_num = $urandom_range(0, 300);
            else
                pitch_num = $urandom_range(0, 99999);
            put_text($sformatf("%0d", pitch_num));
        end
        if ($urandom_range(0, 99) < 80) begin
            line_buf.push_back(COMMA_CODE);
            pick = $urandom_range(0, 99);
            if (pick >= 10) begin
                dur_num = (pick < 85) ? $urandom_range(0, 25) : $urandom_range(0, 99999);
                put_text($sformatf("%0d", dur_num));
            end
        end
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 3)) begin
                slot = $urandom_range(0, line_buf.size());
                line_buf.insert(slot, junk_byte());
            end
        end
        if ($urandom_range(0, 99) < 8) begin
            pad_to = $urandom_range(LINE_LIMIT - 1, LINE_LIMIT + 4);
            while (line_buf.size() < pad_to)
                line_buf.push_back(junk_byte());
        end
        send_line_buf();
        if ($urandom_range(0, 99) < 5)
            wait_drained();
        send_beat(FUNC_BYTE, CR_CODE);
    endtask

    // Random traffic across several limit settings
    task automatic test_random_traffic();
        int phase;
        int start;
        int pick;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: ;
                1: set_limits(11'd246, 11'd2000);
                2: set_limits(11'd246, 11'd246);
                3: set_limits(11'd2000, 11'd2000);
                4: set_limits(11'd2000, 11'd246);
                default: set_limits(PITCH_W'($urandom_range(246, 2000)),
                                    PITCH_W'($urandom_range(246, 2000)));
            endcase
            start = items_sent;
            while (items_sent - start < RANDOM_ITEMS / RANDOM_PHASES) begin
                calm = ($urandom_range(0, 9) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_random_line();
                    if ($urandom_range(0, 9) == 0)
                        send_ticks($urandom_range(20, 40));
                    else
                        send_ticks($urandom_range(0, 12));
                end else if (pick < 85) begin
                    send_ticks($urandom_range(1, 10));
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_beat(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
                end
            end
        end
        calm = 1'b0;
    endtask

    // Receiver back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            out_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 20)
                stall_left = pick_gap();
        end
    end

    // Compare each status beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            got_st.tone   = out_ch.tone_compare;
            got_st.beep   = out_ch.beeping;
            got_st.loaded = out_ch.command_loaded;
            if (expected_status.size() == 0) begin
                errors++;
                if (shown < SHOW_LIMIT) begin
                    shown++;
                    $display("unexpected status beat: tone_compare %0d beeping %0b loaded %0b",
                             got_st.tone, got_st.beep, got_st.loaded);
                end
            end else begin
                want_st = expected_status.pop_front();
                if (got_st !== want_st) begin
                    errors++;
                    if (shown < SHOW_LIMIT) begin
                        shown++;
                        $display("mismatch at result %0d: tone_compare exp %0d got %0d, %s",
                                 results_seen, want_st.tone, got_st.tone,
                                 $sformatf("beeping exp %0b got %0b, loaded exp %0b got %0b",
                                           want_st.beep, got_st.beep,
                                           want_st.loaded, got_st.loaded));
                    end
                end
            end
        end
    end

    // Watchdog: too long with no beat moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_MIN_PITCH;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.func    = FUNC_BYTE;
        in_ch.rx_byte = '0;
        out_ch.ready  = 1'b0;
        items_sent       = 0;
        ticks_sent       = 0;
        results_seen     = 0;
        loads_predicted  = 0;
        lines_dropped    = 0;
        settings_applied = 0;
        errors           = 0;
        shown            = 0;
        quiet_cycles     = 0;
        stall_left       = 0;
        calm             = 1'b0;
        reset_beeper();

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_ticks();
        test_command_lines();
        test_line_limit();
        test_pitch_limits();
        test_random_traffic();

        wait_drained();
        if (expected_status.size() != 0)
            errors += expected_status.size();

        $display("Covered %0d beats (%0d ticks), %0d status beats checked, %0d commands loaded",
                 items_sent, ticks_sent, results_seen, loads_predicted);
        $display("  %0d overlong lines dropped, %0d pitch limit settings, %0d errors",
                 lines_dropped, settings_applied, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
